// ===== sv/sact_pkg.sv =====
// ----------------------------------------------------------------------------
// Cache tag array package
// Shared constants, command codes and types of the tag array.
// ----------------------------------------------------------------------------
package sact_pkg;

  localparam int unsigned NumSetsDefault = 64;
  localparam int unsigned NumWaysDefault = 4;

  localparam int unsigned ModeW = 4;
  localparam int unsigned BlkW  = 32;
  localparam int unsigned SetW  = 6;
  localparam int unsigned WayW  = 2;
  localparam int unsigned TimeW = 32;
  localparam int unsigned TagW  = 26;

  typedef enum logic [ModeW-1:0] {
    CmdProbe    = 4'd0,
    CmdTouch    = 4'd1,
    CmdWrDirty  = 4'd2,
    CmdVictim   = 4'd3,
    CmdAlloc    = 4'd4,
    CmdInval    = 4'd5,
    CmdInvalAll = 4'd6,
    CmdDirtyChk = 4'd7,
    CmdFindDirty = 4'd8,
    CmdFlush    = 4'd9
  } cmd_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [BlkW-1:0]  block_index;
    logic [SetW-1:0]  set_index;
    logic [WayW-1:0]  way_index;
    logic [TimeW-1:0] access_time;
  } req_t;

  typedef struct packed {
    logic            found;
    logic [WayW-1:0] way_out;
    logic [SetW-1:0] set_out;
    logic [TagW-1:0] tag_out;
  } rsp_t;

endpackage

// ===== sv/sact_if.sv =====
// ----------------------------------------------------------------------------
// Cache tag array channel interfaces
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface sact_req_if
  import sact_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [BlkW-1:0]  block_index;
  logic [SetW-1:0]  set_index;
  logic [WayW-1:0]  way_index;
  logic [TimeW-1:0] access_time;
  modport source (output valid, mode, block_index, set_index, way_index, access_time,
                  input ready);
  modport sink (input valid, mode, block_index, set_index, way_index, access_time,
                output ready);
endinterface

interface sact_rsp_if
  import sact_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic            found;
  logic [WayW-1:0] way_out;
  logic [SetW-1:0] set_out;
  logic [TagW-1:0] tag_out;
  modport source (output valid, found, way_out, set_out, tag_out, input ready);
  modport sink (input valid, found, way_out, set_out, tag_out, output ready);
endinterface

// ===== sv/set_assoc_cache_tag_array.sv =====
// Steps: each command is popped, its set row is read, then it executes and its
// result is held until taken; find-dirty reads and checks the sets in order until a dirty line is found.
// Flow: the single set read-modify-write sequencer in the back end takes a new
// command only after the last result is taken; the two-entry queue absorbs input bursts.
// Reset: valid and dirty bits clear at once; tags and times need no reset.
// ----------------------------------------------------------------------------
// Set-associative cache tag array
// Write-back tag store with LRU victim choice and dirty-line search.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_array
  import sact_pkg::*;
#(
  parameter int unsigned NumSets = NumSetsDefault,
  parameter int unsigned NumWays = NumWaysDefault
) (
  input logic clk_i,
  input logic rst_ni,
  sact_req_if.sink   req,
  sact_rsp_if.source rsp
);

  // The front end takes command transfers into a two-entry queue so that the
  // sender is not held while a result waits on the output side, until the queue is full.
  logic q_valid, q_pop;
  req_t q_data;

  sact_front u_front (
    .clk_i, .rst_ni, .req,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  // The back end runs each command against one set (invalidate-all clears every
  // set), or walks the sets in order when looking for the first dirty line.
  sact_back #(.NumSets(NumSets), .NumWays(NumWays)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data), .rsp
  );

endmodule

// ===== sv/sact_front.sv =====
// ----------------------------------------------------------------------------
// Cache tag array front end
// Accepts commands and keeps them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sact_front
  import sact_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sact_req_if.sink req,
  output logic q_valid_o,
  input  logic q_pop_i,
  output req_t q_data_o
);

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign req.ready = (cnt_q != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{req.mode, req.block_index, req.set_index, req.way_index,
                       req.access_time};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push && !q_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count lost a push");

endmodule

// ===== sv/sact_back.sv =====
// ----------------------------------------------------------------------------
// Cache tag array back end
// Reads one set, updates it and builds the result; scans sets for dirty lines.
// ----------------------------------------------------------------------------
module sact_back
  import sact_pkg::*;
#(
  parameter int unsigned NumSets = NumSetsDefault,
  parameter int unsigned NumWays = NumWaysDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_pop_o,
  input  req_t q_data_i,
  sact_rsp_if.source rsp
);

  localparam int unsigned SIdxW = $clog2(NumSets);
  localparam int unsigned WIdxW = (NumWays > 1) ? $clog2(NumWays) : 1;
  localparam int unsigned SCntW = $clog2(NumSets + 1);

  typedef enum logic [2:0] {
    StIdle, StRead, StExec, StScan, StScanChk, StOut
  } state_e;

  // Tag and time storage per set: one row holds all ways.
  logic [NumWays-1:0][TagW-1:0]  tag_mem  [NumSets];
  logic [NumWays-1:0][TimeW-1:0] time_mem [NumSets];
  logic [NumWays-1:0][TagW-1:0]  tag_rd_q;
  logic [NumWays-1:0][TimeW-1:0] time_rd_q;
  logic [NumSets-1:0][NumWays-1:0] valid_q, dirty_q;

  state_e           state_q;
  req_t             cur_q;
  logic [SIdxW-1:0] set_q;
  logic [SCntW-1:0] scan_q;
  rsp_t             out_q;
  logic             mem_we;
  logic [SIdxW-1:0] rd_addr;
  logic [BlkW-1:0]  blk_tag_full;
  logic [TagW-1:0]  btag;
  logic [SIdxW-1:0] bset;
  cmd_e             cmd;

  assign cmd          = cmd_e'(cur_q.mode);
  assign bset         = cur_q.block_index[SIdxW-1:0];
  assign blk_tag_full = cur_q.block_index >> SIdxW;
  assign btag         = blk_tag_full[TagW-1:0];

  // Wrap of indexes wider than the array: masked with the count minus one, a modulo for powers of two.
  logic [SIdxW-1:0] cset_w;
  logic [WIdxW-1:0] cway_w;
  always_comb begin
    cset_w = (NumSets >= (1 << SetW)) ? SIdxW'(cur_q.set_index) :
             SIdxW'(cur_q.set_index & SetW'(NumSets - 1));
    cway_w = (NumWays >= (1 << WayW)) ? WIdxW'(cur_q.way_index) :
             WIdxW'(cur_q.way_index & WayW'(NumWays - 1));
    if (NumWays == 1) cway_w = '0;
  end

  // Set addressed by the current command: block commands use the block's set.
  logic [SIdxW-1:0] sel_set;
  assign sel_set = (cmd == CmdProbe || cmd == CmdVictim || cmd == CmdAlloc ||
                    cmd == CmdDirtyChk) ? bset : cset_w;

  // Per-way matches and victim select on the registered row.
  logic [NumWays-1:0] vrow, drow;
  logic             hit, dhit, allv, vfound;
  logic [WIdxW-1:0] hway, dway, vway, sway;
  logic [TimeW-1:0] best_t;
  always_comb begin
    vrow = valid_q[set_q];
    drow = dirty_q[set_q];
    hit = 1'b0; dhit = 1'b0; hway = '0; dway = '0;
    vway = '0; allv = 1'b1; best_t = time_rd_q[0];
    vfound = 1'b0; sway = '0;
    for (int w = 0; w < NumWays; w++) begin
      if (!hit && vrow[w] && tag_rd_q[w] == btag) begin
        hit = 1'b1; hway = WIdxW'(w);
      end
      if (!dhit && vrow[w] && drow[w] && tag_rd_q[w] == btag) begin
        dhit = 1'b1; dway = WIdxW'(w);
      end
      if (!vfound && vrow[w] && drow[w]) begin
        vfound = 1'b1; sway = WIdxW'(w);
      end
    end
    for (int w = NumWays - 1; w >= 0; w--) begin
      if (!vrow[w]) begin
        allv = 1'b0; vway = WIdxW'(w);
      end
    end
    if (allv) begin
      vway = '0;
      for (int w = 1; w < NumWays; w++) begin
        if (time_rd_q[w] < best_t) begin
          best_t = time_rd_q[w]; vway = WIdxW'(w);
        end
      end
    end
  end

  assign mem_we = (state_q == StExec) && (cmd == CmdAlloc);
  // The row for a command is read at the edge that leaves StRead, so that it
  // is registered when the command executes.
  assign rd_addr = (state_q == StScan) ? scan_q[SIdxW-1:0] :
                   (state_q == StRead) ? sel_set : set_q;

  always_ff @(posedge clk_i) begin
    tag_rd_q  <= tag_mem[rd_addr];
    time_rd_q <= time_mem[rd_addr];
    if (mem_we) begin
      tag_mem[bset][cway_w] <= btag;
    end
    if (state_q == StExec &&
        (mem_we || ((cmd == CmdTouch || cmd == CmdWrDirty) && vrow[cway_w]))) begin
      time_mem[set_q][cway_w] <= cur_q.access_time;
    end
  end

  assign q_pop_o   = (state_q == StIdle) && q_valid_i;
  assign rsp.valid = (state_q == StOut);
  assign rsp.found   = out_q.found;
  assign rsp.way_out = out_q.way_out;
  assign rsp.set_out = out_q.set_out;
  assign rsp.tag_out = out_q.tag_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      dirty_q <= '0;
      cur_q   <= '0;
      set_q   <= '0;
      scan_q  <= '0;
      out_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (q_valid_i) begin
            cur_q   <= q_data_i;
            state_q <= StRead;
          end
        end
        StRead: begin
          // Select the set; data arrives registered in StExec.
          set_q   <= sel_set;
          scan_q  <= '0;
          out_q   <= '0;
          state_q <= (cmd == CmdFindDirty) ? StScan : StExec;
        end
        StExec: begin
          state_q <= StOut;
          case (cmd)
            CmdProbe: begin
              out_q.found <= hit; out_q.way_out <= WayW'(hway);
            end
            CmdTouch: ;
            CmdWrDirty: begin
              if (vrow[cway_w]) dirty_q[set_q][cway_w] <= 1'b1;
            end
            CmdVictim: begin
              out_q.way_out <= WayW'(vway);
              if (vrow[vway]) begin
                out_q.tag_out <= tag_rd_q[vway];
                out_q.found   <= drow[vway];
              end
            end
            CmdAlloc: begin
              valid_q[set_q][cway_w] <= 1'b1;
              dirty_q[set_q][cway_w] <= 1'b0;
            end
            CmdInval: begin
              valid_q[set_q][cway_w] <= 1'b0;
              dirty_q[set_q][cway_w] <= 1'b0;
            end
            CmdInvalAll: begin
              valid_q <= '0;
              dirty_q <= '0;
            end
            CmdDirtyChk: begin
              out_q.found <= dhit; out_q.way_out <= WayW'(dway);
            end
            CmdFlush: dirty_q[set_q][cway_w] <= 1'b0;
            default: ;
          endcase
        end
        StScan: begin
          // Read of set scan_q is issued; check it next cycle.
          set_q   <= scan_q[SIdxW-1:0];
          state_q <= StScanChk;
        end
        StScanChk: begin
          if (vfound) begin
            out_q.found   <= 1'b1;
            out_q.way_out <= WayW'(sway);
            out_q.set_out <= SetW'(set_q);
            out_q.tag_out <= tag_rd_q[sway];
            state_q       <= StOut;
          end else if (scan_q == SCntW'(NumSets - 1)) begin
            state_q <= StOut;
          end else begin
            scan_q  <= scan_q + SCntW'(1);
            state_q <= StScan;
          end
        end
        StOut: begin
          if (rsp.ready) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) (dirty_q & ~valid_q) == '0)
    else $error("dirty line that is not valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(out_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   q_pop_o |=> state_q == StRead)
    else $error("popped command not started");

endmodule
